// ----- hw/rtl/adc_trigger_and_result_control_top_macros.svh -----
// Assertion helpers for the checker file atrc_checker.sv.
`ifndef ADC_TRIGGER_AND_RESULT_CONTROL_TOP_MACROS_SVH
`define ADC_TRIGGER_AND_RESULT_CONTROL_TOP_MACROS_SVH

// Check a property on every clock edge, muted while reset is high.
`define ATRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ATRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/atrc_pkg.sv -----
package atrc_pkg;

   // Field widths fixed by the register map and result format
   localparam int SAMPLE_BITS_DEFAULT       = 12;
   localparam int EXTERNAL_CHANNELS_DEFAULT = 26;
   localparam int CHANNEL_BITS              = 6;
   localparam int BYTE_BITS                 = 8;
   localparam int RESULT_BITS               = 16;
   localparam int COUNT_BITS                = 32;
   localparam int PIN_BITS                  = 5;
   localparam int CSR_INDEX_BITS            = 4;
   localparam int CSR_DATA_BITS             = 8;

   localparam logic [BYTE_BITS-1:0] TRIG_PIN_RESET = 8'h7F;

   // Register indexes on the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MODULE_ENABLE      = 4'd0,
      REG_RIGHT_JUSTIFY      = 4'd1,
      REG_CHANNEL_SELECT     = 4'd2,
      REG_REGULATOR_ENABLE   = 4'd3,
      REG_PIN_IS_ANALOG      = 4'd4,
      REG_TRIGGER_CONTROL    = 4'd5,
      REG_INTERRUPT_ENABLE   = 4'd6,
      REG_TRIGGER_PIN_SELECT = 4'd7
   } reg_index_type;

   // Item kinds
   localparam logic FUNC_SW_WRITE  = 1'b0;
   localparam logic FUNC_PIN_LEVEL = 1'b1;

   // Trigger source and edge codes
   localparam logic [1:0] TRIG_SRC_PIN  = 2'd3;
   localparam logic [1:0] EDGE_FALLING = 2'd0;
   localparam logic [1:0] EDGE_RISING  = 2'd1;

   // Refusal reasons
   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_REGULATOR = 2'd1,
      FAULT_MUX       = 2'd2
   } fault_type;

endpackage

// ----- hw/rtl/atrc_req_if.sv -----
interface atrc_req_if
   import atrc_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic                   go_bit;
   logic                   pin_level;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, func, go_bit, pin_level, sample, input ready);
   modport sink   (input valid, func, go_bit, pin_level, sample, output ready);
endinterface

// ----- hw/rtl/atrc_rsp_if.sv -----
interface atrc_rsp_if
   import atrc_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic                  converted;
   logic [BYTE_BITS-1:0]  result_high;
   logic [BYTE_BITS-1:0]  result_low;
   logic [1:0]            fault_reason;
   logic                  irq_raised;
   logic [COUNT_BITS-1:0] conversion_total;
   logic [COUNT_BITS-1:0] regulator_fault_total;
   logic [COUNT_BITS-1:0] mux_fault_total;

   modport source (output valid, converted, result_high, result_low, fault_reason,
                   irq_raised, conversion_total, regulator_fault_total,
                   mux_fault_total, input ready);
   modport sink   (input valid, converted, result_high, result_low, fault_reason,
                   irq_raised, conversion_total, regulator_fault_total,
                   mux_fault_total, output ready);
endinterface

// ----- hw/rtl/atrc_csr_if.sv -----
interface atrc_csr_if
   import atrc_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/adc_trigger_and_result_control_top.sv -----
// ADC trigger and result control.
// req: one beat per software control write (func 0, go_bit) or trigger pin
//   level sample (func 1, pin_level), each with the current channel sample.
// rsp: exactly one beat per req beat, in order: converted flag, justified
//   result bytes, refusal reason, interrupt flag and the three counters as
//   they stand after that beat.
// csr: register writes (index, data), always ready; the user must write
//   only while idle, since the block itself does not enforce it.
// Flow: an accepted req beat is registered in the input register, then
//   decided and packed into the output register, which drives rsp.valid.
// Throughput: one beat per cycle while the output is not stalled; the
//   decision path is one pin compare, the edge gate and one 32-bit
//   increment between the input register and the output register.
// Stall: while rsp.ready is low the output register holds its beat, the
//   input register can still take one more beat, then req.ready drops.
// Reset: synchronous, clears both pipeline valids, the edge tracker, the
//   counters and the registers to their reset values (trigger pin 0x7F).
module adc_trigger_and_result_control_top
   import atrc_pkg::*;
#(
   parameter int SAMPLE_BITS       = SAMPLE_BITS_DEFAULT,
   parameter int EXTERNAL_CHANNELS = EXTERNAL_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   atrc_req_if.sink    req,
   atrc_rsp_if.source  rsp,
   atrc_csr_if.sink    csr
);

   // Configuration registers
   logic                    enable_ff;
   logic                    right_ff;
   logic [CHANNEL_BITS-1:0] channel_ff;
   logic                    regulator_ff;
   logic                    analog_ff;
   logic [BYTE_BITS-1:0]    trigctl_ff;
   logic                    irq_en_ff;
   logic [BYTE_BITS-1:0]    trigpin_ff;

   // Edge tracker and counters
   logic [PIN_BITS-1:0]   tracked_pin_ff,  tracked_pin_in;
   logic                  tracked_vld_ff,  tracked_vld_in;
   logic                  prev_level_ff,   prev_level_in;
   logic                  primed_ff,       primed_in;
   logic [COUNT_BITS-1:0] conv_cnt_ff,     conv_cnt_in;
   logic [COUNT_BITS-1:0] reg_fault_ff,    reg_fault_in;
   logic [COUNT_BITS-1:0] mux_fault_ff,    mux_fault_in;

   // Input register
   logic                   s1_valid_ff;
   logic                   s1_func_ff;
   logic                   s1_go_ff;
   logic                   s1_level_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;

   // Output register
   logic                  out_valid_ff;
   logic                  out_conv_ff,   out_conv_in;
   logic [BYTE_BITS-1:0]  out_high_ff,   out_high_in;
   logic [BYTE_BITS-1:0]  out_low_ff,    out_low_in;
   fault_type             out_reason_ff, out_reason_in;
   logic                  out_irq_ff,    out_irq_in;

   logic s1_advance;
   logic trig_gate;
   logic pin_valid;
   logic [PIN_BITS-1:0] pin_sel;
   logic pin_change;
   logic primed_eff;
   logic [1:0] edge_sel;
   logic start;
   logic external;
   logic [SAMPLE_BITS-1:0] raw;
   logic [RESULT_BITS-1:0] packed_res;

   // Handshakes
   assign s1_advance = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_advance;
   assign csr.ready  = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         right_ff     <= 1'b0;
         channel_ff   <= '0;
         regulator_ff <= 1'b0;
         analog_ff    <= 1'b0;
         trigctl_ff   <= '0;
         irq_en_ff    <= 1'b0;
         trigpin_ff   <= TRIG_PIN_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            REG_MODULE_ENABLE:      enable_ff    <= csr.data[0];
            REG_RIGHT_JUSTIFY:      right_ff     <= csr.data[0];
            REG_CHANNEL_SELECT:     channel_ff   <= csr.data[CHANNEL_BITS-1:0];
            REG_REGULATOR_ENABLE:   regulator_ff <= csr.data[0];
            REG_PIN_IS_ANALOG:      analog_ff    <= csr.data[0];
            REG_TRIGGER_CONTROL:    trigctl_ff   <= csr.data;
            REG_INTERRUPT_ENABLE:   irq_en_ff    <= csr.data[0];
            REG_TRIGGER_PIN_SELECT: trigpin_ff   <= csr.data;
            default: ;
         endcase
      end
   end

   // Capture an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         s1_func_ff   <= req.func;
         s1_go_ff     <= req.go_bit;
         s1_level_ff  <= req.pin_level;
         s1_sample_ff <= req.sample;
      end
   end

   // Decode trigger pin: port below 4 and bit below 8
   assign trig_gate  = enable_ff && trigctl_ff[7] && (trigctl_ff[5:4] == TRIG_SRC_PIN);
   assign pin_valid  = !trigpin_ff[6] && !trigpin_ff[3];
   assign pin_sel    = {trigpin_ff[5:4], trigpin_ff[2:0]};
   assign pin_change = !tracked_vld_ff || (pin_sel != tracked_pin_ff);
   assign primed_eff = primed_ff && !pin_change;
   assign edge_sel   = trigctl_ff[3:2];

   // Track pin level and decide whether this beat starts a conversion
   always_comb begin
      tracked_pin_in = tracked_pin_ff;
      tracked_vld_in = tracked_vld_ff;
      prev_level_in  = prev_level_ff;
      primed_in      = primed_ff;
      start          = 1'b0;
      if (s1_func_ff == FUNC_SW_WRITE) begin
         start = s1_go_ff && enable_ff;
      end else if (trig_gate && pin_valid) begin
         tracked_pin_in = pin_sel;
         tracked_vld_in = 1'b1;
         prev_level_in  = s1_level_ff;
         primed_in      = 1'b1;
         if (primed_eff) begin
            if (edge_sel == EDGE_FALLING && prev_level_ff && !s1_level_ff) begin
               start = 1'b1;
            end
            if (edge_sel == EDGE_RISING && !prev_level_ff && s1_level_ff) begin
               start = 1'b1;
            end
         end
      end
   end

   // Pack the sample; internal channels read zero
   assign external   = channel_ff < CHANNEL_BITS'(EXTERNAL_CHANNELS);
   assign raw        = external ? s1_sample_ff : '0;
   assign packed_res = right_ff ? RESULT_BITS'(raw)
                                : RESULT_BITS'(raw) << (RESULT_BITS - SAMPLE_BITS);

   // Check regulator then pin mode, update counters
   always_comb begin
      conv_cnt_in   = conv_cnt_ff;
      reg_fault_in  = reg_fault_ff;
      mux_fault_in  = mux_fault_ff;
      out_conv_in   = 1'b0;
      out_high_in   = '0;
      out_low_in    = '0;
      out_reason_in = FAULT_NONE;
      out_irq_in    = 1'b0;
      if (start) begin
         if (!regulator_ff) begin
            out_reason_in = FAULT_REGULATOR;
            if (reg_fault_ff != '1) begin
               reg_fault_in = reg_fault_ff + COUNT_BITS'(1);
            end
         end else if (external && !analog_ff) begin
            out_reason_in = FAULT_MUX;
            if (mux_fault_ff != '1) begin
               mux_fault_in = mux_fault_ff + COUNT_BITS'(1);
            end
         end else begin
            out_conv_in = 1'b1;
            out_high_in = packed_res[RESULT_BITS-1:BYTE_BITS];
            out_low_in  = packed_res[BYTE_BITS-1:0];
            out_irq_in  = irq_en_ff;
            conv_cnt_in = conv_cnt_ff + COUNT_BITS'(1);
         end
      end
   end

   // Commit state as the beat moves to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_pin_ff <= '0;
         tracked_vld_ff <= 1'b0;
         prev_level_ff  <= 1'b0;
         primed_ff      <= 1'b0;
         conv_cnt_ff    <= '0;
         reg_fault_ff   <= '0;
         mux_fault_ff   <= '0;
      end else if (s1_advance) begin
         tracked_pin_ff <= tracked_pin_in;
         tracked_vld_ff <= tracked_vld_in;
         prev_level_ff  <= prev_level_in;
         primed_ff      <= primed_in;
         conv_cnt_ff    <= conv_cnt_in;
         reg_fault_ff   <= reg_fault_in;
         mux_fault_ff   <= mux_fault_in;
      end
   end

   // Output register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (s1_advance) begin
         out_conv_ff   <= out_conv_in;
         out_high_ff   <= out_high_in;
         out_low_ff    <= out_low_in;
         out_reason_ff <= out_reason_in;
         out_irq_ff    <= out_irq_in;
      end
   end

   assign rsp.valid                 = out_valid_ff;
   assign rsp.converted             = out_conv_ff;
   assign rsp.result_high           = out_high_ff;
   assign rsp.result_low            = out_low_ff;
   assign rsp.fault_reason          = out_reason_ff;
   assign rsp.irq_raised            = out_irq_ff;
   assign rsp.conversion_total      = conv_cnt_ff;
   assign rsp.regulator_fault_total = reg_fault_ff;
   assign rsp.mux_fault_total       = mux_fault_ff;

endmodule

// ----- hw/rtl/atrc_checker.sv -----
`include "adc_trigger_and_result_control_top_macros.svh"

module atrc_checker
   import atrc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_converted,
   input logic [BYTE_BITS-1:0] rsp_result_high,
   input logic [BYTE_BITS-1:0] rsp_result_low,
   input logic [1:0]           rsp_fault_reason,
   input logic                 rsp_irq_raised
);

   // A stalled result beat stays offered
   `ATRC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped while stalled")

   // No result beat right after reset
   `ATRC_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // A refused or idle beat carries zero bytes and no interrupt
   `ATRC_ASSERT(a_no_conv_clean, clock, reset, rsp_valid && !rsp_converted |-> rsp_result_high == '0 && rsp_result_low == '0 && !rsp_irq_raised, "result data without conversion")

   // A completed conversion carries no refusal reason
   `ATRC_ASSERT(a_conv_no_fault, clock, reset, rsp_valid && rsp_converted |-> rsp_fault_reason == FAULT_NONE, "fault reason on a conversion")

endmodule

bind adc_trigger_and_result_control_top atrc_checker u_atrc_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_converted    (rsp.converted),
   .rsp_result_high  (rsp.result_high),
   .rsp_result_low   (rsp.result_low),
   .rsp_fault_reason (rsp.fault_reason),
   .rsp_irq_raised   (rsp.irq_raised)
);

// ----- tb/adc_trigger_and_result_control_checker.sv -----
`timescale 1ns / 1ps

module adc_trigger_and_result_control_checker
   import atrc_pkg::*;
#(
   parameter int SAMPLE_BITS       = SAMPLE_BITS_DEFAULT,
   parameter int EXTERNAL_CHANNELS = EXTERNAL_CHANNELS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic                      req_func,
   input  logic                      req_go_bit,
   input  logic                      req_pin_level,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   // result channel
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_converted,
   input  logic [BYTE_BITS-1:0]      rsp_result_high,
   input  logic [BYTE_BITS-1:0]      rsp_result_low,
   input  logic [1:0]                rsp_fault_reason,
   input  logic                      rsp_irq_raised,
   input  logic [COUNT_BITS-1:0]     rsp_conversion_total,
   input  logic [COUNT_BITS-1:0]     rsp_regulator_fault_total,
   input  logic [COUNT_BITS-1:0]     rsp_mux_fault_total,
   // register write channel
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   // status toward the stimulus side
   output int                        mismatch_count,
   output int                        results_pending
);

   // Trigger pin select is valid only below these port and bit numbers
   localparam int PORT_LIMIT   = 4;
   localparam int BIT_LIMIT    = 8;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic                  converted;
      logic [BYTE_BITS-1:0]  result_high;
      logic [BYTE_BITS-1:0]  result_low;
      fault_type             reason;
      logic                  irq_raised;
      logic [COUNT_BITS-1:0] conversion_total;
      logic [COUNT_BITS-1:0] regulator_fault_total;
      logic [COUNT_BITS-1:0] mux_fault_total;
   } adc_result_type;

   // Shadow registers
   logic                     cfg_enable;
   logic                     cfg_right;
   logic [CHANNEL_BITS-1:0]  cfg_channel;
   logic                     cfg_regulator;
   logic                     cfg_analog;
   logic [BYTE_BITS-1:0]     cfg_trigger;
   logic                     cfg_irq_en;
   logic [BYTE_BITS-1:0]     cfg_trig_pin;

   // Edge tracker and counters
   logic [PIN_BITS-1:0]      watched_pin;
   logic                     watched_valid;
   logic                     prior_level;
   logic                     level_seen;
   logic [COUNT_BITS-1:0]    conversions;
   logic [COUNT_BITS-1:0]    regulator_refusals;
   logic [COUNT_BITS-1:0]    mux_refusals;

   adc_result_type           expected_results[$];
   int                       mismatches;

   // Decide one beat: gate the start, check regulator and pin mode, pack the sample
   function automatic adc_result_type decide_conversion(input logic kind, input logic go,
                                                        input logic level,
                                                        input logic [SAMPLE_BITS-1:0] value);
      adc_result_type        res;
      logic                  start;
      logic                  external;
      logic [2:0]            port_num;
      logic [3:0]            bit_num;
      logic [PIN_BITS-1:0]   pin;
      logic [RESULT_BITS-1:0] packed_word;
      res         = '0;
      res.reason  = FAULT_NONE;
      start       = 1'b0;
      external    = (cfg_channel < EXTERNAL_CHANNELS);
      port_num    = cfg_trig_pin[6:4];
      bit_num     = cfg_trig_pin[3:0];
      if (kind == FUNC_SW_WRITE) begin
         start = go && cfg_enable;
      end else if (cfg_enable && cfg_trigger[7] && cfg_trigger[5:4] == TRIG_SRC_PIN) begin
         if (port_num < PORT_LIMIT && bit_num < BIT_LIMIT) begin
            pin = {port_num[1:0], bit_num[2:0]};
            // re-prime the detector when a different pin is selected
            if (!watched_valid || pin != watched_pin) begin
               watched_pin   = pin;
               watched_valid = 1'b1;
               level_seen    = 1'b0;
            end
            if (!level_seen) begin
               prior_level = level;
               level_seen  = 1'b1;
            end else begin
               if (cfg_trigger[3:2] == EDGE_FALLING && prior_level && !level) start = 1'b1;
               if (cfg_trigger[3:2] == EDGE_RISING && !prior_level && level) start = 1'b1;
               prior_level = level;
            end
         end
      end
      if (start) begin
         if (!cfg_regulator) begin
            if (regulator_refusals != '1) regulator_refusals = regulator_refusals + 1'b1;
            res.reason = FAULT_REGULATOR;
         end else if (external && !cfg_analog) begin
            if (mux_refusals != '1) mux_refusals = mux_refusals + 1'b1;
            res.reason = FAULT_MUX;
         end else begin
            packed_word = external ? RESULT_BITS'(value) : '0;
            if (!cfg_right) packed_word = packed_word << (RESULT_BITS - SAMPLE_BITS);
            res.converted   = 1'b1;
            res.result_high = packed_word[RESULT_BITS-1:BYTE_BITS];
            res.result_low  = packed_word[BYTE_BITS-1:0];
            res.irq_raised  = cfg_irq_en;
            conversions     = conversions + 1'b1;
         end
      end
      res.conversion_total      = conversions;
      res.regulator_fault_total = regulator_refusals;
      res.mux_fault_total       = mux_refusals;
      return res;
   endfunction

   always @(posedge clock) begin : watch_channels
      adc_result_type want;
      if (reset) begin
         cfg_enable         = 1'b0;
         cfg_right          = 1'b0;
         cfg_channel        = '0;
         cfg_regulator      = 1'b0;
         cfg_analog         = 1'b0;
         cfg_trigger        = '0;
         cfg_irq_en         = 1'b0;
         cfg_trig_pin       = TRIG_PIN_RESET;
         watched_pin        = '0;
         watched_valid      = 1'b0;
         prior_level        = 1'b0;
         level_seen         = 1'b0;
         conversions        = '0;
         regulator_refusals = '0;
         mux_refusals       = '0;
         mismatches         = 0;
         expected_results.delete();
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_MODULE_ENABLE:      cfg_enable    = csr_data[0];
               REG_RIGHT_JUSTIFY:      cfg_right     = csr_data[0];
               REG_CHANNEL_SELECT:     cfg_channel   = csr_data[CHANNEL_BITS-1:0];
               REG_REGULATOR_ENABLE:   cfg_regulator = csr_data[0];
               REG_PIN_IS_ANALOG:      cfg_analog    = csr_data[0];
               REG_TRIGGER_CONTROL:    cfg_trigger   = csr_data;
               REG_INTERRUPT_ENABLE:   cfg_irq_en    = csr_data[0];
               REG_TRIGGER_PIN_SELECT: cfg_trig_pin  = csr_data;
               default: ;
            endcase
         end
         // predict each accepted request beat
         if (req_valid && req_ready) begin
            expected_results.push_back(decide_conversion(req_func, req_go_bit,
                                                         req_pin_level, req_sample));
         end
         // compare each accepted result beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result beat with no request outstanding", $realtime);
            end else begin
               want = expected_results.pop_front();
               if (rsp_converted !== want.converted ||
                   rsp_result_high !== want.result_high ||
                   rsp_result_low !== want.result_low ||
                   rsp_fault_reason !== want.reason ||
                   rsp_irq_raised !== want.irq_raised ||
                   rsp_conversion_total !== want.conversion_total ||
                   rsp_regulator_fault_total !== want.regulator_fault_total ||
                   rsp_mux_fault_total !== want.mux_fault_total) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected conv=%0b hi=%02h lo=%02h reason=%0d irq=%0b",
                              want.converted, want.result_high, want.result_low,
                              want.reason, want.irq_raised);
                     $display("            conversions=%0d reg_faults=%0d mux_faults=%0d",
                              want.conversion_total, want.regulator_fault_total,
                              want.mux_fault_total);
                     $display("   actual   conv=%0b hi=%02h lo=%02h reason=%0d irq=%0b",
                              rsp_converted, rsp_result_high, rsp_result_low,
                              rsp_fault_reason, rsp_irq_raised);
                     $display("            conversions=%0d reg_faults=%0d mux_faults=%0d",
                              rsp_conversion_total, rsp_regulator_fault_total,
                              rsp_mux_fault_total);
                  end
               end
            end
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= expected_results.size();
   end

endmodule

// ----- tb/adc_trigger_and_result_control_top_tb.sv -----
`timescale 1ns / 1ps

module adc_trigger_and_result_control_top_tb;
   import atrc_pkg::*;

   localparam int SAMPLE_BITS       = SAMPLE_BITS_DEFAULT;
   localparam int EXTERNAL_CHANNELS = EXTERNAL_CHANNELS_DEFAULT;
   localparam int ITEM_TARGET       = 1820;
   localparam int QUIET_ITEMS       = 250;
   localparam int CYCLE_LIMIT       = 400000;
   localparam int MAX_GAP           = 13;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   results_pending;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   idle_pct    = 0;
   bit   no_idle     = 1'b0;

   atrc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   atrc_rsp_if                              rsp_bus ();
   atrc_csr_if                              csr_bus ();

   adc_trigger_and_result_control_top #(
      .SAMPLE_BITS       (SAMPLE_BITS),
      .EXTERNAL_CHANNELS (EXTERNAL_CHANNELS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   adc_trigger_and_result_control_checker #(
      .SAMPLE_BITS       (SAMPLE_BITS),
      .EXTERNAL_CHANNELS (EXTERNAL_CHANNELS)
   ) u_checker (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_bus.valid),
      .req_ready                 (req_bus.ready),
      .req_func                  (req_bus.func),
      .req_go_bit                (req_bus.go_bit),
      .req_pin_level             (req_bus.pin_level),
      .req_sample                (req_bus.sample),
      .rsp_valid                 (rsp_bus.valid),
      .rsp_ready                 (rsp_bus.ready),
      .rsp_converted             (rsp_bus.converted),
      .rsp_result_high           (rsp_bus.result_high),
      .rsp_result_low            (rsp_bus.result_low),
      .rsp_fault_reason          (rsp_bus.fault_reason),
      .rsp_irq_raised            (rsp_bus.irq_raised),
      .rsp_conversion_total      (rsp_bus.conversion_total),
      .rsp_regulator_fault_total (rsp_bus.regulator_fault_total),
      .rsp_mux_fault_total       (rsp_bus.mux_fault_total),
      .csr_valid                 (csr_bus.valid),
      .csr_ready                 (csr_bus.ready),
      .csr_index                 (csr_bus.index),
      .csr_data                  (csr_bus.data),
      .mismatch_count            (mismatch_count),
      .results_pending           (results_pending)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result side: alternate ready runs with stall bursts, no stalls in the tail
   initial begin : result_backpressure
      int run_left;
      run_left      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (no_idle) begin
            rsp_bus.ready = 1'b1;
         end else if (run_left == 0) begin
            if (rsp_bus.ready) begin
               rsp_bus.ready = 1'b0;
               run_left      = $urandom_range(1, MAX_GAP);
            end else begin
               rsp_bus.ready = 1'b1;
               run_left      = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                           : $urandom_range(1, 20);
            end
         end
         if (run_left > 0) run_left--;
      end
   end

   function automatic logic [7:0] trigger_word(input logic hw_en, input logic [1:0] src,
                                               input logic [1:0] edge_code);
      return {hw_en, 1'b0, src, edge_code, 2'b00};
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Present one request beat, with an optional idle burst ahead of it
   task automatic send_beat(input logic kind, input logic go, input logic level,
                            input logic [SAMPLE_BITS-1:0] value);
      int gap;
      @(negedge clock);
      if (!no_idle && $urandom_range(1, 100) <= idle_pct) begin
         req_bus.valid = 1'b0;
         gap           = $urandom_range(1, MAX_GAP);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.func      = kind;
      req_bus.go_bit    = go;
      req_bus.pin_level = level;
      req_bus.sample    = value;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Hold the sender until every predicted result has come back
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (results_pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin : stimulus
      int                     n_items;
      logic                   level;
      logic                   go;
      logic                   kind;
      logic [1:0]             edge_code;
      logic [SAMPLE_BITS-1:0] value;
      logic [7:0]             trig;
      logic [7:0]             pin_sel;
      logic [7:0]             chan;

      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_SW_WRITE;
      req_bus.go_bit    = 1'b0;
      req_bus.pin_level = 1'b0;
      req_bus.sample    = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = REG_MODULE_ENABLE;
      csr_bus.data      = '0;
      reset             = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Module disabled: nothing starts, pin samples are ignored
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, '1);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, '0);
      settle();

      // Regulator off wins over pin not analog
      write_reg(REG_MODULE_ENABLE, 8'h01);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, '1);
      send_beat(FUNC_SW_WRITE, 1'b0, 1'b0, '1);
      settle();

      // Pin not analog on an external channel
      write_reg(REG_REGULATOR_ENABLE, 8'h01);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'h123);
      settle();

      // Internal channel reads zero even with the pin not analog
      write_reg(REG_CHANNEL_SELECT, 8'h3F);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'hABC);
      settle();

      // Left then right justified on the top external channel
      write_reg(REG_CHANNEL_SELECT, 8'd25);
      write_reg(REG_PIN_IS_ANALOG, 8'h01);
      write_reg(REG_INTERRUPT_ENABLE, 8'h01);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'hFFF);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'h000);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'h5A3);
      settle();
      write_reg(REG_RIGHT_JUSTIFY, 8'h01);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'hFFF);
      send_beat(FUNC_SW_WRITE, 1'b1, 1'b0, 12'h801);
      settle();

      // Falling-edge trigger with no valid pin selected: ignored
      write_reg(REG_TRIGGER_CONTROL, trigger_word(1'b1, TRIG_SRC_PIN, EDGE_FALLING));
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'h111);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'h222);
      settle();

      // First sample primes, then falling edges convert
      write_reg(REG_TRIGGER_PIN_SELECT, 8'h00);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'h333);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'h444);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'h555);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'h666);
      settle();

      // New pin re-primes; rising edge converts
      write_reg(REG_TRIGGER_PIN_SELECT, 8'h37);
      write_reg(REG_TRIGGER_CONTROL, trigger_word(1'b1, TRIG_SRC_PIN, EDGE_RISING));
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'h777);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'h888);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'h999);
      settle();

      // Edge code that never triggers, all control bits set
      write_reg(REG_TRIGGER_CONTROL, 8'hFF);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'hAAA);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'hBBB);
      settle();

      // Gating off: wrong source, then hardware trigger disabled
      write_reg(REG_TRIGGER_CONTROL, trigger_word(1'b1, 2'd2, EDGE_RISING));
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'hCCC);
      settle();
      write_reg(REG_TRIGGER_CONTROL, 8'h00);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'hDDD);
      settle();

      // Invalid pin selects: port out of range, bit out of range
      write_reg(REG_TRIGGER_CONTROL, trigger_word(1'b1, TRIG_SRC_PIN, EDGE_FALLING));
      write_reg(REG_TRIGGER_PIN_SELECT, 8'hFF);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b0, 12'hEEE);
      settle();
      write_reg(REG_TRIGGER_PIN_SELECT, 8'h08);
      send_beat(FUNC_PIN_LEVEL, 1'b0, 1'b1, 12'h0F0);
      settle();

      // Random phases: fresh settings, then a burst of beats
      level = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= ITEM_TARGET - QUIET_ITEMS) no_idle = 1'b1;

         case ($urandom_range(0, 5))
            0:       chan = 8'd0;
            1:       chan = 8'(EXTERNAL_CHANNELS - 1);
            2:       chan = 8'($urandom_range(EXTERNAL_CHANNELS, 63));
            default: chan = 8'($urandom_range(0, EXTERNAL_CHANNELS - 1));
         endcase
         chan[7:6] = 2'($urandom());
         edge_code = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                                 : 2'($urandom_range(0, 1));
         if ($urandom_range(0, 3) != 0)
            trig = {1'b1, 1'($urandom()), TRIG_SRC_PIN, edge_code, 2'($urandom())};
         else
            trig = 8'($urandom());
         if ($urandom_range(0, 4) != 0)
            pin_sel = {1'($urandom()), 1'b0, 2'($urandom_range(0, 1)), 1'b0,
                       3'($urandom_range(0, 2))};
         else
            pin_sel = 8'($urandom());

         write_reg(REG_MODULE_ENABLE,      {7'($urandom()), 1'($urandom_range(0, 9) != 0)});
         write_reg(REG_RIGHT_JUSTIFY,      {7'($urandom()), 1'($urandom())});
         write_reg(REG_CHANNEL_SELECT,     chan);
         write_reg(REG_REGULATOR_ENABLE,   {7'($urandom()), 1'($urandom_range(0, 7) != 0)});
         write_reg(REG_PIN_IS_ANALOG,      {7'($urandom()), 1'($urandom_range(0, 5) != 0)});
         write_reg(REG_TRIGGER_CONTROL,    trig);
         write_reg(REG_INTERRUPT_ENABLE,   {7'($urandom()), 1'($urandom())});
         write_reg(REG_TRIGGER_PIN_SELECT, pin_sel);

         idle_pct = 10 * $urandom_range(0, 3);
         n_items  = $urandom_range(40, 80);
         repeat (n_items) begin
            kind = ($urandom_range(0, 4) == 0) ? FUNC_SW_WRITE : FUNC_PIN_LEVEL;
            go   = ($urandom_range(0, 3) != 0);
            // lean toward toggling so edges are frequent
            if ($urandom_range(0, 9) < 6) level = ~level;
            case ($urandom_range(0, 9))
               0:       value = '0;
               1:       value = '1;
               default: value = SAMPLE_BITS'($urandom());
            endcase
            send_beat(kind, go, level, value);
         end
         settle();
      end

      // Drain and give the verdict
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
